// File: src/vm_register_alu_execute_defines.svh
// Assertion macros shared by the register ALU sources.
// Needs nothing else; define ASSERT_OFF to compile the checks away.
`ifndef VM_REGISTER_ALU_EXECUTE_DEFINES_SVH
`define VM_REGISTER_ALU_EXECUTE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/vmra_pkg.sv
// Shared widths, operation codes and payload types of the register ALU.
// Used by the channel interfaces, the ALU core and the top level.
package vmra_pkg;

   localparam int NUM_REGS_DEFAULT = 16;

   localparam int FUNC_W  = 5;
   localparam int REG_W   = 4;
   localparam int IMM_W   = 12;
   localparam int KEY_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 16;
   localparam int JUMP_W  = 12;
   localparam int HUND_W  = 2;
   localparam int DIGIT_W = 4;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_SET_IMM     = 5'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD_IMM     = 5'd1;
   localparam logic [FUNC_W-1:0] FUNC_COPY        = 5'd2;
   localparam logic [FUNC_W-1:0] FUNC_OR          = 5'd3;
   localparam logic [FUNC_W-1:0] FUNC_AND         = 5'd4;
   localparam logic [FUNC_W-1:0] FUNC_XOR         = 5'd5;
   localparam logic [FUNC_W-1:0] FUNC_ADD         = 5'd6;
   localparam logic [FUNC_W-1:0] FUNC_SUB_XY      = 5'd7;
   localparam logic [FUNC_W-1:0] FUNC_SUB_YX      = 5'd8;
   localparam logic [FUNC_W-1:0] FUNC_SHR         = 5'd9;
   localparam logic [FUNC_W-1:0] FUNC_SHL         = 5'd10;
   localparam logic [FUNC_W-1:0] FUNC_SKIP_EQ_IMM = 5'd11;
   localparam logic [FUNC_W-1:0] FUNC_SKIP_NE_IMM = 5'd12;
   localparam logic [FUNC_W-1:0] FUNC_SKIP_EQ_REG = 5'd13;
   localparam logic [FUNC_W-1:0] FUNC_SKIP_NE_REG = 5'd14;
   localparam logic [FUNC_W-1:0] FUNC_SET_INDEX   = 5'd15;
   localparam logic [FUNC_W-1:0] FUNC_ADD_INDEX   = 5'd16;
   localparam logic [FUNC_W-1:0] FUNC_BCD         = 5'd17;
   localparam logic [FUNC_W-1:0] FUNC_KEY_DOWN    = 5'd18;
   localparam logic [FUNC_W-1:0] FUNC_KEY_UP      = 5'd19;
   localparam logic [FUNC_W-1:0] FUNC_WAIT_KEY    = 5'd20;
   localparam logic [FUNC_W-1:0] FUNC_JUMP_OFFSET = 5'd21;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [REG_W-1:0]  reg_x;
      logic [REG_W-1:0]  reg_y;
      logic [IMM_W-1:0]  immediate;
      logic [KEY_W-1:0]  key_state;
   } req_type;

   typedef struct packed {
      logic               skip_next;
      logic               repeat_instruction;
      logic [JUMP_W-1:0]  jump_target;
      logic [INDEX_W-1:0] index_value;
      logic [HUND_W-1:0]  digit_hundreds;
      logic [DIGIT_W-1:0] digit_tens;
      logic [DIGIT_W-1:0] digit_ones;
      logic [BYTE_W-1:0]  reg_x_value;
   } rsp_type;

   // ALU result plus the state updates it asks for
   typedef struct packed {
      rsp_type            rsp;
      logic               vx_we;
      logic [BYTE_W-1:0]  vx_data;
      logic               flag_we;
      logic [BYTE_W-1:0]  flag_data;
      logic               index_we;
      logic [INDEX_W-1:0] index_data;
   } alu_out_type;

endpackage

// File: src/vmra_if.sv
// Valid/ready channel interfaces for requests and results of the register ALU.
// Depends on vmra_pkg for the field widths.
interface vmra_req_if import vmra_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [REG_W-1:0]   reg_x;
   logic [REG_W-1:0]   reg_y;
   logic [IMM_W-1:0]   immediate;
   logic [KEY_W-1:0]   key_state;

   modport source (output valid, func, reg_x, reg_y, immediate, key_state, input ready);
   modport sink   (input valid, func, reg_x, reg_y, immediate, key_state, output ready);
endinterface

interface vmra_rsp_if import vmra_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               skip_next;
   logic               repeat_instruction;
   logic [JUMP_W-1:0]  jump_target;
   logic [INDEX_W-1:0] index_value;
   logic [HUND_W-1:0]  digit_hundreds;
   logic [DIGIT_W-1:0] digit_tens;
   logic [DIGIT_W-1:0] digit_ones;
   logic [BYTE_W-1:0]  reg_x_value;

   modport source (output valid, skip_next, repeat_instruction, jump_target, index_value,
                   digit_hundreds, digit_tens, digit_ones, reg_x_value, input ready);
   modport sink   (input valid, skip_next, repeat_instruction, jump_target, index_value,
                   digit_hundreds, digit_tens, digit_ones, reg_x_value, output ready);
endinterface

// File: src/vmra_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Stand-alone; no package needed.
module vmra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read ports return the contents before a same-cycle write
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end

endmodule

// File: src/vmra_alu.sv
// Combinational execute logic of the register ALU: one instruction per call.
// Depends on vmra_pkg for codes and types; operands arrive already resolved.
module vmra_alu import vmra_pkg::*; (
   input  req_type            req,
   input  logic [BYTE_W-1:0]  vx,
   input  logic [BYTE_W-1:0]  vb,
   input  logic [INDEX_W-1:0] index_cur,
   output alu_out_type        result
);

   logic [BYTE_W-1:0]  imm_byte;
   logic [BYTE_W:0]    sum;
   logic [BYTE_W-1:0]  rem_h;
   logic [6:0]         rem;
   logic [14:0]        tens_prod;
   logic [DIGIT_W-1:0] tens;
   logic [6:0]         ones;
   logic [HUND_W-1:0]  hund;
   logic [KEY_W-1:0]   key_low;
   logic [REG_W-1:0]   key_num;
   logic               key_any;
   logic               key_hit;

   assign imm_byte = req.immediate[BYTE_W-1:0];
   assign sum      = {1'b0, vx} + {1'b0, vb};

   // split vx into hundreds by compare, then tens by reciprocal multiply
   always_comb begin
      if (vx >= 8'd200) begin
         hund  = 2'd2;
         rem_h = vx - 8'd200;
      end else if (vx >= 8'd100) begin
         hund  = 2'd1;
         rem_h = vx - 8'd100;
      end else begin
         hund  = 2'd0;
         rem_h = vx;
      end
      rem       = rem_h[6:0];
      tens_prod = 15'(rem) * 15'd205;
      tens      = tens_prod[14:11];
      ones      = rem - 7'(tens) * 7'd10;
   end

   // isolate the lowest pressed key and encode its number
   always_comb begin
      key_low = req.key_state & (~req.key_state + 16'd1);
      key_any = |req.key_state;
      key_num = '0;
      for (int k = 0; k < KEY_W; k++) begin
         key_num = key_num | ({REG_W{key_low[k]}} & REG_W'(k));
      end
   end

   assign key_hit = req.key_state[vx[REG_W-1:0]];

   // decode and execute
   always_comb begin
      result = '0;
      case (req.func)
         FUNC_SET_IMM: begin
            result.vx_we   = 1'b1;
            result.vx_data = imm_byte;
         end
         FUNC_ADD_IMM: begin
            result.vx_we   = 1'b1;
            result.vx_data = vx + imm_byte;
         end
         FUNC_COPY: begin
            result.vx_we   = 1'b1;
            result.vx_data = vb;
         end
         FUNC_OR: begin
            result.vx_we   = 1'b1;
            result.vx_data = vx | vb;
         end
         FUNC_AND: begin
            result.vx_we   = 1'b1;
            result.vx_data = vx & vb;
         end
         FUNC_XOR: begin
            result.vx_we   = 1'b1;
            result.vx_data = vx ^ vb;
         end
         FUNC_ADD: begin
            result.flag_we   = 1'b1;
            result.flag_data = {7'd0, sum[BYTE_W]};
            result.vx_we     = 1'b1;
            result.vx_data   = sum[BYTE_W-1:0];
         end
         FUNC_SUB_XY: begin
            result.flag_we   = 1'b1;
            result.flag_data = {7'd0, vx >= vb};
            result.vx_we     = 1'b1;
            result.vx_data   = vx - vb;
         end
         FUNC_SUB_YX: begin
            result.flag_we   = 1'b1;
            result.flag_data = {7'd0, vb >= vx};
            result.vx_we     = 1'b1;
            result.vx_data   = vb - vx;
         end
         FUNC_SHR: begin
            result.flag_we   = 1'b1;
            result.flag_data = {7'd0, vx[0]};
            result.vx_we     = 1'b1;
            result.vx_data   = {1'b0, vx[BYTE_W-1:1]};
         end
         FUNC_SHL: begin
            result.flag_we   = 1'b1;
            result.flag_data = {7'd0, vx[BYTE_W-1]};
            result.vx_we     = 1'b1;
            result.vx_data   = {vx[BYTE_W-2:0], 1'b0};
         end
         FUNC_SKIP_EQ_IMM: result.rsp.skip_next = (vx == imm_byte);
         FUNC_SKIP_NE_IMM: result.rsp.skip_next = (vx != imm_byte);
         FUNC_SKIP_EQ_REG: result.rsp.skip_next = (vx == vb);
         FUNC_SKIP_NE_REG: result.rsp.skip_next = (vx != vb);
         FUNC_SET_INDEX: begin
            result.index_we   = 1'b1;
            result.index_data = {4'd0, req.immediate};
         end
         FUNC_ADD_INDEX: begin
            result.index_we   = 1'b1;
            result.index_data = index_cur + {8'd0, vx};
         end
         FUNC_BCD: begin
            result.rsp.digit_hundreds = hund;
            result.rsp.digit_tens     = tens;
            result.rsp.digit_ones     = ones[DIGIT_W-1:0];
         end
         FUNC_KEY_DOWN: result.rsp.skip_next = key_hit;
         FUNC_KEY_UP:   result.rsp.skip_next = !key_hit;
         FUNC_WAIT_KEY: begin
            result.rsp.repeat_instruction = !key_any;
            result.vx_we                  = key_any;
            result.vx_data                = {4'd0, key_num};
         end
         FUNC_JUMP_OFFSET: result.rsp.jump_target = {4'd0, vb} + req.immediate;
         default: ;
      endcase
      // reported state after the step
      result.rsp.index_value = result.index_we ? result.index_data : index_cur;
      result.rsp.reg_x_value = result.vx_we ? result.vx_data : vx;
   end

endmodule

// File: src/vm_register_alu_execute.sv
// Register ALU execute unit: takes one register-class instruction per cycle and
// returns one result per instruction. A request is accepted every cycle while the
// result side keeps up; its result is offered after the execute stage commits it.
// The steps follow the registered read of the general register file: the request
// edge addresses the file, the execute cycle resolves operands (flag register and
// last write forwarded), computes and commits, and the result register holds the
// answer until taken. Reset clears all registers to zero at once through
// per-entry valid bits; no clearing pass is needed.
`include "vm_register_alu_execute_defines.svh"

module vm_register_alu_execute import vmra_pkg::*; #(
   parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   vmra_req_if.sink  req_if,
   vmra_rsp_if.source rsp_if
);

   localparam int REG_AW = $clog2(NUM_REGS);
   localparam logic [REG_AW-1:0] FLAG_REG = REG_AW'(NUM_REGS - 1);
   localparam logic [REG_AW-1:0] ZERO_REG = '0;

   logic                req_fire;
   logic                exec_fire;
   logic [REG_AW-1:0]   rd_addr_a;
   logic [REG_AW-1:0]   rd_addr_b;
   logic [BYTE_W-1:0]   rdata_a;
   logic [BYTE_W-1:0]   rdata_b;
   logic [BYTE_W-1:0]   op_x;
   logic [BYTE_W-1:0]   op_b;
   logic [REG_AW-1:0]   addr_x;
   logic                ram_we;
   alu_out_type         alu_res;

   logic                exec_valid_ff, exec_valid_in;
   req_type             exec_req_ff, exec_req_in;
   logic [REG_AW-1:0]   exec_addr_b_ff, exec_addr_b_in;
   logic                ok_a_ff, ok_a_in;
   logic                ok_b_ff, ok_b_in;
   logic [NUM_REGS-1:0] reg_valid_ff, reg_valid_in;
   logic [BYTE_W-1:0]   flag_ff, flag_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [REG_AW-1:0]   fwd_addr_ff, fwd_addr_in;
   logic [BYTE_W-1:0]   fwd_data_ff, fwd_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // handshake; hold off requests while in reset
   assign exec_fire    = exec_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !reset && (!exec_valid_ff || exec_fire);
   assign req_fire     = req_if.valid && req_if.ready;

   // read addresses: jump reads register zero on the second port
   assign rd_addr_a = req_if.reg_x[REG_AW-1:0];
   assign rd_addr_b = (req_if.func == FUNC_JUMP_OFFSET) ? ZERO_REG : req_if.reg_y[REG_AW-1:0];

   // register file; the flag register lives in flip-flops beside it
   vmra_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (addr_x),
      .wdata   (alu_res.vx_data),
      .re      (req_fire),
      .raddr_a (rd_addr_a),
      .raddr_b (rd_addr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // resolve operands: flag, then last write, then file (unwritten reads zero)
   assign addr_x = exec_req_ff.reg_x[REG_AW-1:0];

   always_comb begin
      if (addr_x == FLAG_REG) begin
         op_x = flag_ff;
      end else if (fwd_valid_ff && fwd_addr_ff == addr_x) begin
         op_x = fwd_data_ff;
      end else if (ok_a_ff) begin
         op_x = rdata_a;
      end else begin
         op_x = '0;
      end
      if (exec_addr_b_ff == FLAG_REG) begin
         op_b = flag_ff;
      end else if (fwd_valid_ff && fwd_addr_ff == exec_addr_b_ff) begin
         op_b = fwd_data_ff;
      end else if (ok_b_ff) begin
         op_b = rdata_b;
      end else begin
         op_b = '0;
      end
   end

   vmra_alu u_alu (
      .req       (exec_req_ff),
      .vx        (op_x),
      .vb        (op_b),
      .index_cur (index_ff),
      .result    (alu_res)
   );

   assign ram_we = exec_fire && alu_res.vx_we && (addr_x != FLAG_REG);

   // next state
   always_comb begin
      exec_valid_in  = exec_valid_ff;
      exec_req_in    = exec_req_ff;
      exec_addr_b_in = exec_addr_b_ff;
      ok_a_in        = ok_a_ff;
      ok_b_in        = ok_b_ff;
      reg_valid_in   = reg_valid_ff;
      flag_in        = flag_ff;
      index_in       = index_ff;
      fwd_valid_in   = fwd_valid_ff;
      fwd_addr_in    = fwd_addr_ff;
      fwd_data_in    = fwd_data_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      // drain the result register
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // commit: flag first, then register x
      if (exec_fire) begin
         exec_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_data_in   = alu_res.rsp;
         if (alu_res.flag_we) begin
            flag_in = alu_res.flag_data;
         end
         if (alu_res.vx_we && addr_x == FLAG_REG) begin
            flag_in = alu_res.vx_data;
         end
         if (ram_we) begin
            reg_valid_in[addr_x] = 1'b1;
            fwd_valid_in         = 1'b1;
            fwd_addr_in          = addr_x;
            fwd_data_in          = alu_res.vx_data;
         end
         if (alu_res.index_we) begin
            index_in = alu_res.index_data;
         end
      end

      // load a new request into execute
      if (req_fire) begin
         exec_valid_in  = 1'b1;
         exec_req_in    = '{func: req_if.func, reg_x: req_if.reg_x, reg_y: req_if.reg_y,
                            immediate: req_if.immediate, key_state: req_if.key_state};
         exec_addr_b_in = rd_addr_b;
         ok_a_in        = reg_valid_ff[rd_addr_a];
         ok_b_in        = reg_valid_ff[rd_addr_b];
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         reg_valid_ff  <= '0;
         flag_ff       <= '0;
         index_ff      <= '0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         reg_valid_ff  <= reg_valid_in;
         flag_ff       <= flag_in;
         index_ff      <= index_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      exec_req_ff    <= exec_req_in;
      exec_addr_b_ff <= exec_addr_b_in;
      ok_a_ff        <= ok_a_in;
      ok_b_ff        <= ok_b_in;
      fwd_addr_ff    <= fwd_addr_in;
      fwd_data_ff    <= fwd_data_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // result channel
   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.skip_next          = rsp_data_ff.skip_next;
   assign rsp_if.repeat_instruction = rsp_data_ff.repeat_instruction;
   assign rsp_if.jump_target        = rsp_data_ff.jump_target;
   assign rsp_if.index_value        = rsp_data_ff.index_value;
   assign rsp_if.digit_hundreds     = rsp_data_ff.digit_hundreds;
   assign rsp_if.digit_tens         = rsp_data_ff.digit_tens;
   assign rsp_if.digit_ones         = rsp_data_ff.digit_ones;
   assign rsp_if.reg_x_value        = rsp_data_ff.reg_x_value;

   // checks
   `ASSERT_IMPLY(a_no_flag_ram_write, clock, reset, ram_we, addr_x != FLAG_REG,
                 "register file written at the flag address")
   `ASSERT_NEXT(a_exec_holds, clock, reset, exec_valid_ff && !exec_fire, exec_valid_ff,
                "stalled instruction dropped from execute")
   `ASSERT_IMPLY(a_skip_repeat_excl, clock, reset, rsp_valid_ff,
                 !(rsp_data_ff.skip_next && rsp_data_ff.repeat_instruction),
                 "skip and repeat reported together")
   `ASSERT_IMPLY(a_bcd_digits, clock, reset, rsp_valid_ff,
                 rsp_data_ff.digit_tens < 4'd10 && rsp_data_ff.digit_ones < 4'd10 &&
                 rsp_data_ff.digit_hundreds != 2'd3,
                 "BCD digit out of range")

endmodule

// File: tb/tb_vm_register_alu_execute.sv
// Testbench for the register ALU execute unit: directed and random instructions,
// checked against a behavioral predictor held in a small scoreboard class.
// Depends on vmra_pkg, the vmra_req_if/vmra_rsp_if channels and vm_register_alu_execute.
module tb_vm_register_alu_execute;
   timeunit 1ns;
   timeprecision 1ps;

   import vmra_pkg::*;

   localparam int FUNC_MAX       = 2**FUNC_W - 1;
   localparam int FLAG_REG       = 15;
   localparam int STALL_LIMIT    = 2000;
   localparam int RANDOM_ITEMS   = 1625;

   // Register-file and index-register predictor plus the queue of pending results
   class alu_scoreboard;
      bit [BYTE_W-1:0]  vreg [16];
      bit [INDEX_W-1:0] index_q;
      rsp_type          pending_q [$];
      int               errors;

      task report(input string msg);
         $display("ALU mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Execute one instruction on the shadow state and queue its result
      function void note_request(input req_type r);
         rsp_type          e;
         bit [BYTE_W-1:0]  vx;
         bit [BYTE_W-1:0]  vy;
         bit [BYTE_W:0]    sum;
         bit [BYTE_W-1:0]  ib;
         e   = '0;
         vx  = vreg[r.reg_x];
         vy  = vreg[r.reg_y];
         ib  = r.immediate[BYTE_W-1:0];
         sum = vx + vy;
         case (r.func)
            FUNC_SET_IMM:     vreg[r.reg_x] = ib;
            FUNC_ADD_IMM:     vreg[r.reg_x] = vx + ib;
            FUNC_COPY:        vreg[r.reg_x] = vy;
            FUNC_OR:          vreg[r.reg_x] = vx | vy;
            FUNC_AND:         vreg[r.reg_x] = vx & vy;
            FUNC_XOR:         vreg[r.reg_x] = vx ^ vy;
            FUNC_ADD: begin
               vreg[FLAG_REG] = {7'b0, sum[BYTE_W]};
               vreg[r.reg_x]  = sum[BYTE_W-1:0];
            end
            FUNC_SUB_XY: begin
               vreg[FLAG_REG] = {7'b0, vx >= vy};
               vreg[r.reg_x]  = vx - vy;
            end
            FUNC_SUB_YX: begin
               vreg[FLAG_REG] = {7'b0, vy >= vx};
               vreg[r.reg_x]  = vy - vx;
            end
            FUNC_SHR: begin
               vreg[FLAG_REG] = {7'b0, vx[0]};
               vreg[r.reg_x]  = vx >> 1;
            end
            FUNC_SHL: begin
               vreg[FLAG_REG] = {7'b0, vx[7]};
               vreg[r.reg_x]  = vx << 1;
            end
            FUNC_SKIP_EQ_IMM: e.skip_next = (vx == ib);
            FUNC_SKIP_NE_IMM: e.skip_next = (vx != ib);
            FUNC_SKIP_EQ_REG: e.skip_next = (vx == vy);
            FUNC_SKIP_NE_REG: e.skip_next = (vx != vy);
            FUNC_SET_INDEX:   index_q = INDEX_W'(r.immediate);
            FUNC_ADD_INDEX:   index_q = index_q + INDEX_W'(vx);
            FUNC_BCD: begin
               e.digit_hundreds = HUND_W'(vx / 100);
               e.digit_tens     = DIGIT_W'((vx / 10) % 10);
               e.digit_ones     = DIGIT_W'(vx % 10);
            end
            FUNC_KEY_DOWN:    e.skip_next = r.key_state[vx[3:0]];
            FUNC_KEY_UP:      e.skip_next = !r.key_state[vx[3:0]];
            FUNC_WAIT_KEY: begin
               // scan downward so the lowest pressed key wins
               e.repeat_instruction = 1'b1;
               for (int k = 15; k >= 0; k--) begin
                  if (r.key_state[k]) begin
                     vreg[r.reg_x]        = BYTE_W'(k);
                     e.repeat_instruction = 1'b0;
                  end
               end
            end
            FUNC_JUMP_OFFSET: e.jump_target = JUMP_W'(vreg[0]) + r.immediate;
            default: ;
         endcase
         e.index_value = index_q;
         e.reg_x_value = vreg[r.reg_x];
         pending_q.push_back(e);
      endfunction

      task check_field(input string name, input int got, input int want);
         if (got != want)
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      endtask

      // Compare a delivered result with the oldest pending one
      task check_result(input rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            report("result with no request pending");
         end else begin
            want = pending_q.pop_front();
            check_field("skip_next", got.skip_next, want.skip_next);
            check_field("repeat_instruction", got.repeat_instruction, want.repeat_instruction);
            check_field("jump_target", got.jump_target, want.jump_target);
            check_field("index_value", got.index_value, want.index_value);
            check_field("digit_hundreds", got.digit_hundreds, want.digit_hundreds);
            check_field("digit_tens", got.digit_tens, want.digit_tens);
            check_field("digit_ones", got.digit_ones, want.digit_ones);
            check_field("reg_x_value", got.reg_x_value, want.reg_x_value);
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   stall_cycles;

   alu_scoreboard sb = new;

   vmra_req_if req_bus ();
   vmra_rsp_if rsp_bus ();

   vm_register_alu_execute i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watch both channels at the rising edge and count cycles with no progress
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_type'{req_bus.func, req_bus.reg_x, req_bus.reg_y,
                                      req_bus.immediate, req_bus.key_state});
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_type'{rsp_bus.skip_next, rsp_bus.repeat_instruction,
                                      rsp_bus.jump_target, rsp_bus.index_value,
                                      rsp_bus.digit_hundreds, rsp_bus.digit_tens,
                                      rsp_bus.digit_ones, rsp_bus.reg_x_value});
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Stall the result side at random
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Offer one request, idling first at random; return at the falling edge after acceptance
   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.func      = r.func;
      req_bus.reg_x     = r.reg_x;
      req_bus.reg_y     = r.reg_y;
      req_bus.immediate = r.immediate;
      req_bus.key_state = r.key_state;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_op(input int func, input int rx, input int ry, input int imm,
                          input int keys);
      send_request(req_type'{FUNC_W'(func), REG_W'(rx), REG_W'(ry), IMM_W'(imm),
                             KEY_W'(keys)});
   endtask

   // Bias bytes toward the edges of the range
   function automatic bit [BYTE_W-1:0] rand_byte();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   function automatic bit [KEY_W-1:0] rand_keys();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return KEY_W'(1) << $urandom_range(0, 15);
         2:       return '1;
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // Random instruction of the given operation with content aimed at the corner cases
   function automatic req_type rand_request(input int func);
      req_type r;
      r.func      = FUNC_W'(func);
      r.reg_x     = REG_W'($urandom);
      r.reg_y     = ($urandom_range(0, 3) == 0) ? r.reg_x : REG_W'($urandom);
      r.immediate = IMM_W'($urandom);
      r.key_state = rand_keys();
      // hit the equal case of the immediate compares half the time
      if ($urandom_range(0, 1) == 1)
         r.immediate[BYTE_W-1:0] = sb.vreg[r.reg_x];
      return r;
   endfunction

   // Run random sequences until the given number of instructions was sent
   task automatic run_random(input int count);
      int sent;
      int func;
      int rx;
      int ry;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // load a large value and sweep the index register toward wrap-around
            rx = $urandom_range(0, 15);
            send_op(FUNC_SET_IMM, rx, $urandom, {4'($urandom_range(0, 15)), 4'hF,
                    4'($urandom)}, $urandom);
            repeat (24) send_op(FUNC_ADD_INDEX, rx, $urandom, $urandom, $urandom);
            sent += 25;
         end else if (pick < 40) begin
            // load two registers, then run a random operation on random registers
            rx = $urandom_range(0, 15);
            ry = $urandom_range(0, 15);
            send_op(FUNC_SET_IMM, rx, $urandom, {4'($urandom), rand_byte()}, $urandom);
            send_op(FUNC_SET_IMM, ry, $urandom, {4'($urandom), rand_byte()}, $urandom);
            func = $urandom_range(FUNC_ADD_IMM, FUNC_JUMP_OFFSET);
            if (func == FUNC_SET_INDEX)
               func = FUNC_BCD;
            send_request(rand_request(func));
            sent += 3;
         end else begin
            func = $urandom_range(0, FUNC_MAX);
            // keep index loads rare so the sweeps can wrap
            if (func == FUNC_SET_INDEX && $urandom_range(0, 7) != 0)
               func = FUNC_ADD_INDEX;
            send_request(rand_request(func));
            sent++;
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      stall_cycles      = 0;
      send_idle_pct     = 33;
      recv_idle_pct     = 73;
      req_bus.valid     = 1'b0;
      req_bus.func      = '0;
      req_bus.reg_x     = '0;
      req_bus.reg_y     = '0;
      req_bus.immediate = '0;
      req_bus.key_state = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, every operation and the special cases
      send_op(FUNC_SET_IMM,     0,  0, 'hFFF, 0);
      send_op(FUNC_SET_IMM,     1,  0, 'h001, 0);
      send_op(FUNC_ADD,         0,  1, 0, 0);          // carry out
      send_op(FUNC_SET_IMM,     2,  0, 'h0C8, 0);
      send_op(FUNC_ADD_IMM,     2,  0, 'h0FF, 0);      // byte wrap
      send_op(FUNC_COPY,        3,  2, 0, 0);
      send_op(FUNC_OR,          3,  1, 0, 0);
      send_op(FUNC_AND,         3,  2, 0, 0);
      send_op(FUNC_XOR,         3,  3, 0, 0);
      send_op(FUNC_SUB_XY,      3,  2, 0, 0);          // borrow
      send_op(FUNC_SUB_XY,      2,  2, 0, 0);          // equal operands set the flag
      send_op(FUNC_SUB_YX,      1,  2, 0, 0);
      send_op(FUNC_SET_IMM,     15, 0, 'h081, 0);
      send_op(FUNC_SHR,         15, 0, 0, 0);          // flag register as destination
      send_op(FUNC_SET_IMM,     5,  0, 'hFF0, 0);
      send_op(FUNC_SHL,         5,  0, 0, 0);
      send_op(FUNC_SKIP_EQ_IMM, 5,  0, 'hFE0, 0);      // upper immediate bits ignored
      send_op(FUNC_SKIP_NE_IMM, 5,  0, 'h0E0, 0);
      send_op(FUNC_SKIP_EQ_REG, 5,  5, 0, 0);
      send_op(FUNC_SKIP_NE_REG, 5,  0, 0, 0);
      send_op(FUNC_SET_INDEX,   0,  0, 'hFFF, 0);
      send_op(FUNC_ADD_INDEX,   5,  0, 0, 0);
      send_op(FUNC_BCD,         5,  0, 0, 0);          // 224
      send_op(FUNC_KEY_DOWN,    5,  0, 0, 'h0001);     // key number from low nibble only
      send_op(FUNC_KEY_UP,      5,  0, 0, 'hFFFE);
      send_op(FUNC_WAIT_KEY,    7,  0, 0, 'h0000);     // no key: repeat
      send_op(FUNC_WAIT_KEY,    7,  0, 0, 'h8000);
      send_op(FUNC_JUMP_OFFSET, 0,  0, 'hFFF, 0);
      send_op(FUNC_MAX,         15, 15, 'hFFF, 'hFFFF); // unknown operation

      // random phases: receiver-heavy idling, sender-heavy idling, then none
      run_random(RANDOM_ITEMS / 3);
      send_idle_pct = 73;
      recv_idle_pct = 33;
      run_random(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_bus.valid = 1'b0;

      // drain the pending results, then give stray results a chance to show
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/vmra_pkg.sv
src/vmra_if.sv
src/vmra_ram.sv
src/vmra_alu.sv
src/vm_register_alu_execute.sv
tb/tb_vm_register_alu_execute.sv
